// ===== hw/rtl/psf_pkg.sv =====
// psf_pkg: types and constants shared by the spring force pipeline
// no dependencies; imported by particle_spring_force
package psf_pkg;

  // register indexes on the configuration port
  localparam logic [0:0] REG_STIFFNESS = 1'd0;
  localparam logic [0:0] REG_REST_LEN  = 1'd1;

  localparam logic [31:0] STIFFNESS_RESET = 32'h0001_0000;
  localparam logic [31:0] REST_LEN_RESET  = 32'h0001_0000;

  // pipeline layout; the 66-bit radicand gives 33 root bits
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 31;
  localparam int ST_DIFF    = 0;
  localparam int ST_SQUARE  = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_SQRT0   = 3;
  localparam int ST_DELTA   = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_MPART   = ST_DELTA + 1;
  localparam int ST_MSUM    = ST_MPART + 1;
  localparam int ST_DIV0    = ST_MSUM + 1;
  localparam int ST_FPART   = ST_DIV0 + DIV_STEPS;
  localparam int ST_FOUT    = ST_FPART + 1;
  localparam int NUM_STAGES = ST_FOUT + 1;

  // everything one beat may carry down the pipeline
  typedef struct packed {
    logic [2:0][32:0] mag;
    logic [2:0]       neg;
    logic [2:0][64:0] sq;
    logic             zero;
    logic [65:0]      rad;
    logic [35:0]      rem;
    logic [33:0]      root;
    logic [33:0]      dmag;
    logic             dneg;
    logic [49:0]      ma;
    logic [47:0]      mb;
    logic [50:0]      m;
    logic [2:0][34:0] drem;
    logic [2:0][30:0] quo;
    logic [2:0][62:0] plo;
    logic [2:0][49:0] phi;
    logic [2:0][31:0] force_v;
    logic             sat;
  } psf_beat_t;

endpackage

// ===== hw/rtl/particle_spring_force.sv =====
// particle_spring_force: spring force for a pair of positions, fully pipelined
// throughput one pair per cycle while the output accepts; sqrt (33 steps) and three dividers (31 steps)
// are unrolled one step per stage, each stage handing on under its own valid bit
// a stall at the output fills bubbles before holding the input side
// rst (synchronous) empties every stage and sets k and l to 1.0
module particle_spring_force
  import psf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // self_x, self_y, self_z, other_x, other_y, other_z from bit 0 up
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // force_x, force_y, force_z from bit 0 up
  output logic [95:0]  m_axis_tdata,
  // saturated
  output logic [0:0]   m_axis_tuser
);

  logic [31:0] stiffness;
  logic [31:0] rest_len;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFFNESS_RESET;
      rest_len  <= REST_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STIFFNESS: stiffness <= cfg_data;
        REG_REST_LEN:  rest_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  psf_beat_t             st  [NUM_STAGES];
  psf_beat_t             nxt [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   rdy;

  // a stage moves when it is empty or its successor moves
  assign rdy[NUM_STAGES] = m_axis_tready;
  assign s_axis_tready   = rdy[0];

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_st
    logic in_vld;

    assign rdy[i] = ~vld[i] | rdy[i+1];

    if (i == ST_DIFF) begin : g_diff
      assign in_vld = s_axis_tvalid;
      // difference vector, sign and magnitude
      always_comb begin
        logic [32:0] d;
        nxt[i] = '0;
        for (int k = 0; k < 3; k++) begin
          d = {s_axis_tdata[32*k+31], s_axis_tdata[32*k +: 32]}
            - {s_axis_tdata[32*(k+3)+31], s_axis_tdata[32*(k+3) +: 32]};
          nxt[i].neg[k] = d[32];
          nxt[i].mag[k] = d[32] ? (~d + 33'd1) : d;
        end
      end
    end else begin : g_later
      assign in_vld = vld[i-1];

      if (i == ST_SQUARE) begin : g_sq
        // squared components
        always_comb begin
          nxt[i] = st[i-1];
          for (int k = 0; k < 3; k++) begin
            nxt[i].sq[k] = 65'({33'd0, st[i-1].mag[k]} * {33'd0, st[i-1].mag[k]});
          end
        end
      end else if (i == ST_SUM) begin : g_sum
        // squared length, Q32.32
        always_comb begin
          logic [65:0] s;
          nxt[i] = st[i-1];
          s = {1'b0, st[i-1].sq[0]} + {1'b0, st[i-1].sq[1]} + {1'b0, st[i-1].sq[2]};
          nxt[i].rad  = s;
          nxt[i].zero = (s == 66'd0);
          nxt[i].rem  = '0;
          nxt[i].root = '0;
        end
      end else if (i >= ST_SQRT0 && i < ST_DELTA) begin : g_sqrt
        // one root bit per stage, restoring
        always_comb begin
          logic [37:0] rs;
          logic [37:0] tr;
          nxt[i] = st[i-1];
          rs = {st[i-1].rem, st[i-1].rad[65:64]};
          tr = {2'b00, st[i-1].root, 2'b01};
          nxt[i].rad = {st[i-1].rad[63:0], 2'b00};
          if (rs >= tr) begin
            nxt[i].rem  = 36'(rs - tr);
            nxt[i].root = {st[i-1].root[32:0], 1'b1};
          end else begin
            nxt[i].rem  = rs[35:0];
            nxt[i].root = {st[i-1].root[32:0], 1'b0};
          end
        end
      end else if (i == ST_DELTA) begin : g_delta
        // stretch against rest length
        always_comb begin
          nxt[i] = st[i-1];
          if (st[i-1].root >= {2'b00, rest_len}) begin
            nxt[i].dmag = st[i-1].root - {2'b00, rest_len};
            nxt[i].dneg = 1'b0;
          end else begin
            nxt[i].dmag = {2'b00, rest_len} - st[i-1].root;
            nxt[i].dneg = 1'b1;
          end
        end
      end else if (i == ST_MPART) begin : g_mpart
        // k times stretch, split at the binary point
        always_comb begin
          nxt[i] = st[i-1];
          nxt[i].ma = {18'd0, stiffness} * {32'd0, st[i-1].dmag[33:16]};
          nxt[i].mb = {16'd0, stiffness} * {32'd0, st[i-1].dmag[15:0]};
        end
      end else if (i == ST_MSUM) begin : g_msum
        // force magnitude, divider start
        always_comb begin
          nxt[i] = st[i-1];
          nxt[i].m = {1'b0, st[i-1].ma} + {19'd0, st[i-1].mb[47:16]};
          for (int k = 0; k < 3; k++) begin
            nxt[i].drem[k] = {3'd0, st[i-1].mag[k][32:1]};
            nxt[i].quo[k]  = '0;
          end
        end
      end else if (i >= ST_DIV0 && i < ST_FPART) begin : g_div
        localparam int J = DIV_STEPS - 1 - (i - ST_DIV0);
        // one quotient bit per stage of mag * 2^30 / len
        always_comb begin
          logic [35:0] rs;
          logic        nb;
          nxt[i] = st[i-1];
          for (int k = 0; k < 3; k++) begin
            nb = (J == DIV_STEPS - 1) ? st[i-1].mag[k][0] : 1'b0;
            rs = {st[i-1].drem[k], nb};
            if (rs >= {2'b00, st[i-1].root}) begin
              nxt[i].drem[k]   = 35'(rs - {2'b00, st[i-1].root});
              nxt[i].quo[k][J] = 1'b1;
            end else begin
              nxt[i].drem[k] = rs[34:0];
            end
          end
        end
      end else if (i == ST_FPART) begin : g_fpart
        // m times unit vector, two partial products
        always_comb begin
          nxt[i] = st[i-1];
          for (int k = 0; k < 3; k++) begin
            nxt[i].plo[k] = {31'd0, st[i-1].m[31:0]} * {32'd0, st[i-1].quo[k]};
            nxt[i].phi[k] = {31'd0, st[i-1].m[50:32]} * {19'd0, st[i-1].quo[k]};
          end
        end
      end else begin : g_fout
        // sign, saturation and the zero vector case
        always_comb begin
          logic [81:0] p;
          logic [51:0] f;
          nxt[i] = st[i-1];
          nxt[i].sat = 1'b0;
          for (int k = 0; k < 3; k++) begin
            p = {st[i-1].phi[k], 32'd0} + {19'd0, st[i-1].plo[k]};
            f = p[81:30];
            nxt[i].force_v[k] = '0;
            if (!st[i-1].zero) begin
              if (st[i-1].dneg == st[i-1].neg[k]) begin
                if (f > 52'h0_0000_8000_0000) begin
                  nxt[i].force_v[k] = 32'h8000_0000;
                  nxt[i].sat        = 1'b1;
                end else begin
                  nxt[i].force_v[k] = ~f[31:0] + 32'd1;
                end
              end else begin
                if (f > 52'h0_0000_7FFF_FFFF) begin
                  nxt[i].force_v[k] = 32'h7FFF_FFFF;
                  nxt[i].sat        = 1'b1;
                end else begin
                  nxt[i].force_v[k] = f[31:0];
                end
              end
            end
          end
        end
      end
    end

    // stage register
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= in_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && in_vld) begin
        st[i] <= nxt[i];
      end
    end
  end

  assign m_axis_tvalid = vld[NUM_STAGES-1];
  assign m_axis_tdata  = {st[NUM_STAGES-1].force_v[2], st[NUM_STAGES-1].force_v[1],
                          st[NUM_STAGES-1].force_v[0]};
  assign m_axis_tuser  = st[NUM_STAGES-1].sat;

  // coincident positions leave no force
  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && st[NUM_STAGES-1].zero) |-> (m_axis_tdata == 96'd0 && !m_axis_tuser))
    else $error("nonzero force for coincident positions");

  // the flag only stands beside a clipped component
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000 ||
       m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000 ||
       m_axis_tdata[95:64] == 32'h7FFF_FFFF || m_axis_tdata[95:64] == 32'h8000_0000))
    else $error("saturation flag without a clipped component");

  // an empty last stage lets the input side through
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !vld[NUM_STAGES-1] |-> s_axis_tready)
    else $error("input held with an empty output stage");

  // a moving first stage always reaches the second
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && rdy[1]) |=> vld[1])
    else $error("beat lost between first stages");

endmodule

// ===== tb/tb_particle_spring_force.sv =====
// tb_particle_spring_force: self-checking bench for the spring force pipeline
// predicts each force beat in a scoreboard class; depends on psf_pkg and particle_spring_force
module tb_particle_spring_force
  import psf_pkg::*;
();

  typedef struct {
    logic [31:0] fx, fy, fz;
    logic        sat;
  } force_res_t;

  // predicted forces, oldest first
  class force_board;
    logic [31:0] k_q, l_q;
    force_res_t  pending[$];
    int          errors;

    function new();
      k_q = STIFFNESS_RESET;
      l_q = REST_LEN_RESET;
      errors = 0;
    endfunction

    // floor sqrt of a 66-bit value, 34 result bits
    function automatic logic [33:0] root_of(logic [65:0] s);
      logic [33:0]  r;
      logic [33:0]  c;
      logic [67:0]  c2;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
        c = r | (34'd1 << b);
        c2 = {34'd0, c} * {34'd0, c};
        if (c2 <= {2'b00, s}) r = c;
      end
      return r;
    endfunction

    function automatic void note_pair(logic [191:0] d);
      logic signed [32:0] dv;
      logic [32:0]  mag[3];
      logic         neg[3];
      logic [65:0]  s;
      logic [33:0]  len, dmag;
      logic         dneg, fneg;
      logic [63:0]  m, u, f;
      logic [127:0] p;
      force_res_t   r;
      logic [31:0]  o[3];
      s = 0;
      r.sat = 0;
      for (int i = 0; i < 3; i++) begin
        dv = $signed(d[32*i +: 32]) - $signed(d[32*(i+3) +: 32]);
        neg[i] = dv[32];
        mag[i] = neg[i] ? -dv : dv;
        s += {33'd0, mag[i]} * {33'd0, mag[i]};
      end
      o[0] = 0; o[1] = 0; o[2] = 0;
      if (s != 0) begin
        len = root_of(s);
        dneg = len < {2'b0, l_q};
        dmag = dneg ? {2'b0, l_q} - len : len - {2'b0, l_q};
        m = 64'(k_q) * 64'(dmag >> 16) + ((64'(k_q) * 64'(dmag[15:0])) >> 16);
        for (int i = 0; i < 3; i++) begin
          u = (64'(mag[i]) << 30) / 64'(len);
          fneg = (dneg == neg[i]);
          p = 128'(m) * 128'(u);
          if (p[127:94] != 0) f = 64'd1 << 40;
          else f = p[93:30];
          if (fneg) begin
            if (f > 64'h8000_0000) begin f = 64'h8000_0000; r.sat = 1; end
            o[i] = -f[31:0];
          end else begin
            if (f > 64'h7FFF_FFFF) begin f = 64'h7FFF_FFFF; r.sat = 1; end
            o[i] = f[31:0];
          end
        end
      end
      r.fx = o[0]; r.fy = o[1]; r.fz = o[2];
      pending.push_back(r);
    endfunction

    function automatic void check_force(logic [95:0] d, logic s);
      force_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected force beat %h sat %b", $time, d, s);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.fx) begin
        $display("%0t: force_x exp %h got %h", $time, e.fx, d[31:0]); errors++;
      end
      if (d[63:32] !== e.fy) begin
        $display("%0t: force_y exp %h got %h", $time, e.fy, d[63:32]); errors++;
      end
      if (d[95:64] !== e.fz) begin
        $display("%0t: force_z exp %h got %h", $time, e.fz, d[95:64]); errors++;
      end
      if (s !== e.sat) begin
        $display("%0t: saturated exp %b got %b", $time, e.sat, s); errors++;
      end
    endfunction
  endclass

  logic         clk = 0, rst = 1;
  logic         cfg_we = 0;
  logic [0:0]   cfg_index = REG_STIFFNESS;
  logic [31:0]  cfg_data = 0;
  logic         s_axis_tvalid = 0, s_axis_tready;
  logic [191:0] s_axis_tdata = 0;
  logic         m_axis_tvalid, m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  force_board board = new();
  bit quiet = 0;       // no idling near the end
  bit hold_out = 0;    // long receiver hold-off request

  always #1 clk = ~clk;

  particle_spring_force DUT (.*);

  // result side: check and stall at random
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_force(m_axis_tdata, m_axis_tuser[0]);
  end

  initial begin : sink
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_out) begin
        m_axis_tready <= 0;
        repeat (300) @(posedge clk);
        hold_out = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
    end
  end

  // one register write, then the write port idles before the task returns
  task automatic write_reg(logic [0:0] idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_STIFFNESS) board.k_q = v; else board.l_q = v;
    @(posedge clk);
  endtask

  // offer one pair and wait for its acceptance
  task automatic send_pair(logic [191:0] d);
    int n;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 0;
      n = $urandom_range(1, 15);
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_pair(d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 0);
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [191:0] rand_pair();
    logic [191:0] d;
    for (int i = 0; i < 6; i++) d[32*i +: 32] = coord();
    if ($urandom_range(0, 15) == 0) d[191:96] = d[95:0];  // coincident
    return d;
  endfunction

  function automatic logic [31:0] rand_reg();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  initial begin : stim
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: coincident, rest length, extremes, axes
    send_pair('0);
    send_pair({96'd0, 32'd0, 32'd0, 32'h0001_0000});
    send_pair({96'd0, 32'd0, 32'h0002_0000, 32'd0});
    send_pair({96'd0, 32'h0000_8000, 32'd0, 32'd0});
    send_pair({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
    send_pair({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}});
    send_pair({32'h0, 32'h0, 32'h8000_0000, 64'h0, 32'h7FFF_FFFF});
    send_pair({{3{32'hFFFF_FFFF}}, 96'd0});
    drain();
    write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
    write_reg(REG_REST_LEN, 32'd0);
    send_pair({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
    send_pair({96'd0, 32'd0, 32'd0, 32'h0000_0001});
    send_pair({96'd1, 96'd0});
    drain();
    write_reg(REG_STIFFNESS, 32'd0);
    write_reg(REG_REST_LEN, 32'hFFFF_FFFF);
    send_pair({96'd0, 32'h1234_5678, 32'h0, 32'h0});
    drain();
    // random phases with new settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_STIFFNESS, rand_reg());
      write_reg(REG_REST_LEN, rand_reg());
      if (ph == 3) hold_out = 1;
      if (ph == 9) quiet = 1;
      for (int i = 0; i < 200; i++) send_pair(rand_pair());
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
